@@ design/lfsp_pkg.sv @@
// Shared types, codes and helpers for the link-format stream parser.
`timescale 1ns / 1ps

package lfsp_pkg;

    // Event codes carried in event_res.
    localparam logic [3:0] EV_ENTRY_START = 4'd0;
    localparam logic [3:0] EV_URI_BYTE    = 4'd1;
    localparam logic [3:0] EV_URI_END     = 4'd2;
    localparam logic [3:0] EV_ATTR_START  = 4'd3;
    localparam logic [3:0] EV_NAME_BYTE   = 4'd4;
    localparam logic [3:0] EV_VALUE_START = 4'd5;
    localparam logic [3:0] EV_VALUE_BYTE  = 4'd6;
    localparam logic [3:0] EV_ATTR_END    = 4'd7;
    localparam logic [3:0] EV_ENTRY_END   = 4'd8;
    localparam logic [3:0] EV_TEXT_OK     = 4'd9;
    localparam logic [3:0] EV_ERROR       = 4'd10;

    // Error causes.
    localparam logic [2:0] ERR_EXPECT_LT    = 3'd0;
    localparam logic [2:0] ERR_EMPTY_URI    = 3'd1;
    localparam logic [2:0] ERR_MISSING_GT   = 3'd2;
    localparam logic [2:0] ERR_EXPECT_SEMI  = 3'd3;
    localparam logic [2:0] ERR_EMPTY_NAME   = 3'd4;
    localparam logic [2:0] ERR_OPEN_QUOTE   = 3'd5;

    // Parse phases; unused codes behave as top level.
    localparam logic [3:0] PH_TOP    = 4'd0;
    localparam logic [3:0] PH_URI    = 4'd1;
    localparam logic [3:0] PH_AFTER  = 4'd2;
    localparam logic [3:0] PH_NAME   = 4'd3;
    localparam logic [3:0] PH_VFIRST = 4'd4;
    localparam logic [3:0] PH_UVAL   = 4'd5;
    localparam logic [3:0] PH_QVAL   = 4'd6;
    localparam logic [3:0] PH_QESC   = 4'd7;

    // Delimiter characters.
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    // Most results one text beat can cause.
    localparam int MAX_RES = 3;

    typedef struct packed {
        logic [3:0] event_res;
        logic [7:0] payload_byte;
        logic       has_value;
        logic       quoted;
        logic [2:0] error_cause;
    } lfsp_res_t;

    typedef lfsp_res_t [MAX_RES-1:0] lfsp_res_set_t;

    typedef struct packed {
        logic [3:0] phase;
        logic       seg_nonempty;
        logic       err_hold;
    } lfsp_state_t;

    function automatic lfsp_res_t mk_res(input logic [3:0] ev, input logic [7:0] b,
                                         input logic hv, input logic q,
                                         input logic [2:0] cause);
        lfsp_res_t r;
        r.event_res    = ev;
        r.payload_byte = b;
        r.has_value    = hv;
        r.quoted       = q;
        r.error_cause  = cause;
        return r;
    endfunction

endpackage

@@ design/lfsp_text_if.sv @@
// Input channel carrying text bytes and end-of-text markers.
`timescale 1ns / 1ps

interface lfsp_text_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] text_byte;

    modport source (output valid, output kind, output text_byte, input ready);
    modport sink   (input valid, input kind, input text_byte, output ready);
endinterface

@@ design/lfsp_event_if.sv @@
// Output channel carrying parse events.
`timescale 1ns / 1ps

interface lfsp_event_if;
    logic       valid;
    logic       ready;
    logic [3:0] event_res;
    logic [7:0] payload_byte;
    logic       has_value;
    logic       quoted;
    logic [2:0] error_cause;
    logic       last;

    modport source (output valid, output event_res, output payload_byte, output has_value,
                    output quoted, output error_cause, output last, input ready);
    modport sink   (input valid, input event_res, input payload_byte, input has_value,
                    input quoted, input error_cause, input last, output ready);
endinterface

@@ design/lfsp_decode.sv @@
// Per-beat decode: next parse state and up to three result events.
`timescale 1ns / 1ps

module lfsp_decode
    import lfsp_pkg::*;
(
    input  logic          kind,
    input  logic [7:0]    text_byte,
    input  lfsp_state_t   cur,
    output lfsp_state_t   nxt,
    output lfsp_res_set_t res,
    output logic [1:0]    res_cnt
);

    logic       is_end;
    logic       is_space;
    logic [7:0] c;

    assign is_end   = kind;
    assign c        = text_byte;
    assign is_space = (c inside {[8'd9:8'd13], 8'd32});

    always_comb
    begin
        res     = '0;
        res_cnt = 2'd0;
        nxt     = cur;

        if (cur.err_hold)
        begin
            // Swallow everything until end of text clears the error.
            if (is_end)
            begin
                nxt = '{phase: PH_TOP, seg_nonempty: 1'b0, err_hold: 1'b0};
            end
        end
        else
        begin
            case (cur.phase)
                PH_URI:
                begin
                    if (is_end)
                    begin
                        res[0]  = mk_res(EV_ERROR, 8'd0, 1'b0, 1'b0, ERR_MISSING_GT);
                        res_cnt = 2'd1;
                        nxt     = '{phase: PH_TOP, seg_nonempty: 1'b0, err_hold: 1'b0};
                    end
                    else if (c == CH_GT)
                    begin
                        if (!cur.seg_nonempty)
                        begin
                            res[0]  = mk_res(EV_ERROR, 8'd0, 1'b0, 1'b0, ERR_EMPTY_URI);
                            res_cnt = 2'd1;
                            nxt     = '{phase: PH_TOP, seg_nonempty: 1'b0, err_hold: 1'b1};
                        end
                        else
                        begin
                            res[0]    = mk_res(EV_URI_END, 8'd0, 1'b0, 1'b0, 3'd0);
                            res_cnt   = 2'd1;
                            nxt.phase = PH_AFTER;
                        end
                    end
                    else
                    begin
                        res[0]           = mk_res(EV_URI_BYTE, c, 1'b0, 1'b0, 3'd0);
                        res_cnt          = 2'd1;
                        nxt.seg_nonempty = 1'b1;
                    end
                end
                PH_AFTER:
                begin
                    if (is_end)
                    begin
                        res[0]  = mk_res(EV_ENTRY_END, 8'd0, 1'b0, 1'b0, 3'd0);
                        res[1]  = mk_res(EV_TEXT_OK, 8'd0, 1'b0, 1'b0, 3'd0);
                        res_cnt = 2'd2;
                        nxt     = '{phase: PH_TOP, seg_nonempty: 1'b0, err_hold: 1'b0};
                    end
                    else if (c == CH_SEMI)
                    begin
                        res[0]           = mk_res(EV_ATTR_START, 8'd0, 1'b0, 1'b0, 3'd0);
                        res_cnt          = 2'd1;
                        nxt.phase        = PH_NAME;
                        nxt.seg_nonempty = 1'b0;
                    end
                    else if (c == CH_COMMA)
                    begin
                        res[0]    = mk_res(EV_ENTRY_END, 8'd0, 1'b0, 1'b0, 3'd0);
                        res_cnt   = 2'd1;
                        nxt.phase = PH_TOP;
                    end
                    else
                    begin
                        res[0]  = mk_res(EV_ERROR, 8'd0, 1'b0, 1'b0, ERR_EXPECT_SEMI);
                        res_cnt = 2'd1;
                        nxt     = '{phase: PH_TOP, seg_nonempty: 1'b0, err_hold: 1'b1};
                    end
                end
                PH_NAME:
                begin
                    if (is_end || c == CH_EQ || c == CH_SEMI || c == CH_COMMA)
                    begin
                        if (!cur.seg_nonempty)
                        begin
                            res[0]  = mk_res(EV_ERROR, 8'd0, 1'b0, 1'b0, ERR_EMPTY_NAME);
                            res_cnt = 2'd1;
                            nxt     = '{phase: PH_TOP, seg_nonempty: 1'b0, err_hold: !is_end};
                        end
                        else if (is_end)
                        begin
                            res[0]  = mk_res(EV_ATTR_END, 8'd0, 1'b0, 1'b0, 3'd0);
                            res[1]  = mk_res(EV_ENTRY_END, 8'd0, 1'b0, 1'b0, 3'd0);
                            res[2]  = mk_res(EV_TEXT_OK, 8'd0, 1'b0, 1'b0, 3'd0);
                            res_cnt = 2'd3;
                            nxt     = '{phase: PH_TOP, seg_nonempty: 1'b0, err_hold: 1'b0};
                        end
                        else if (c == CH_EQ)
                        begin
                            res[0]    = mk_res(EV_VALUE_START, 8'd0, 1'b0, 1'b0, 3'd0);
                            res_cnt   = 2'd1;
                            nxt.phase = PH_VFIRST;
                        end
                        else if (c == CH_SEMI)
                        begin
                            res[0]           = mk_res(EV_ATTR_END, 8'd0, 1'b0, 1'b0, 3'd0);
                            res[1]           = mk_res(EV_ATTR_START, 8'd0, 1'b0, 1'b0, 3'd0);
                            res_cnt          = 2'd2;
                            nxt.seg_nonempty = 1'b0;
                        end
                        else
                        begin
                            res[0]  = mk_res(EV_ATTR_END, 8'd0, 1'b0, 1'b0, 3'd0);
                            res[1]  = mk_res(EV_ENTRY_END, 8'd0, 1'b0, 1'b0, 3'd0);
                            res_cnt = 2'd2;
                            nxt     = '{phase: PH_TOP, seg_nonempty: 1'b0, err_hold: 1'b0};
                        end
                    end
                    else
                    begin
                        res[0]           = mk_res(EV_NAME_BYTE, c, 1'b0, 1'b0, 3'd0);
                        res_cnt          = 2'd1;
                        nxt.seg_nonempty = 1'b1;
                    end
                end
                PH_VFIRST, PH_UVAL:
                begin
                    if (!is_end && c == CH_QUOTE && cur.phase == PH_VFIRST)
                    begin
                        nxt.phase = PH_QVAL;
                    end
                    else if (is_end)
                    begin
                        res[0]  = mk_res(EV_ATTR_END, 8'd0, 1'b1, 1'b0, 3'd0);
                        res[1]  = mk_res(EV_ENTRY_END, 8'd0, 1'b0, 1'b0, 3'd0);
                        res[2]  = mk_res(EV_TEXT_OK, 8'd0, 1'b0, 1'b0, 3'd0);
                        res_cnt = 2'd3;
                        nxt     = '{phase: PH_TOP, seg_nonempty: 1'b0, err_hold: 1'b0};
                    end
                    else if (c == CH_SEMI)
                    begin
                        res[0]  = mk_res(EV_ATTR_END, 8'd0, 1'b1, 1'b0, 3'd0);
                        res[1]  = mk_res(EV_ATTR_START, 8'd0, 1'b0, 1'b0, 3'd0);
                        res_cnt = 2'd2;
                        nxt     = '{phase: PH_NAME, seg_nonempty: 1'b0, err_hold: 1'b0};
                    end
                    else if (c == CH_COMMA)
                    begin
                        res[0]  = mk_res(EV_ATTR_END, 8'd0, 1'b1, 1'b0, 3'd0);
                        res[1]  = mk_res(EV_ENTRY_END, 8'd0, 1'b0, 1'b0, 3'd0);
                        res_cnt = 2'd2;
                        nxt     = '{phase: PH_TOP, seg_nonempty: 1'b0, err_hold: 1'b0};
                    end
                    else
                    begin
                        res[0]    = mk_res(EV_VALUE_BYTE, c, 1'b0, 1'b0, 3'd0);
                        res_cnt   = 2'd1;
                        nxt.phase = PH_UVAL;
                    end
                end
                PH_QVAL:
                begin
                    if (is_end)
                    begin
                        res[0]  = mk_res(EV_ERROR, 8'd0, 1'b0, 1'b0, ERR_OPEN_QUOTE);
                        res_cnt = 2'd1;
                        nxt     = '{phase: PH_TOP, seg_nonempty: 1'b0, err_hold: 1'b0};
                    end
                    else if (c == CH_BSLASH)
                    begin
                        nxt.phase = PH_QESC;
                    end
                    else if (c == CH_QUOTE)
                    begin
                        res[0]    = mk_res(EV_ATTR_END, 8'd0, 1'b1, 1'b1, 3'd0);
                        res_cnt   = 2'd1;
                        nxt.phase = PH_AFTER;
                    end
                    else
                    begin
                        res[0]  = mk_res(EV_VALUE_BYTE, c, 1'b0, 1'b0, 3'd0);
                        res_cnt = 2'd1;
                    end
                end
                PH_QESC:
                begin
                    if (is_end)
                    begin
                        res[0]  = mk_res(EV_ERROR, 8'd0, 1'b0, 1'b0, ERR_OPEN_QUOTE);
                        res_cnt = 2'd1;
                        nxt     = '{phase: PH_TOP, seg_nonempty: 1'b0, err_hold: 1'b0};
                    end
                    else
                    begin
                        res[0]    = mk_res(EV_VALUE_BYTE, c, 1'b0, 1'b0, 3'd0);
                        res_cnt   = 2'd1;
                        nxt.phase = PH_QVAL;
                    end
                end
                default:
                begin
                    if (is_end)
                    begin
                        res[0]  = mk_res(EV_TEXT_OK, 8'd0, 1'b0, 1'b0, 3'd0);
                        res_cnt = 2'd1;
                        nxt     = '{phase: PH_TOP, seg_nonempty: 1'b0, err_hold: 1'b0};
                    end
                    else if (is_space || c == CH_COMMA)
                    begin
                        nxt.phase = PH_TOP;
                    end
                    else if (c == CH_LT)
                    begin
                        res[0]  = mk_res(EV_ENTRY_START, 8'd0, 1'b0, 1'b0, 3'd0);
                        res_cnt = 2'd1;
                        nxt     = '{phase: PH_URI, seg_nonempty: 1'b0, err_hold: 1'b0};
                    end
                    else
                    begin
                        res[0]  = mk_res(EV_ERROR, 8'd0, 1'b0, 1'b0, ERR_EXPECT_LT);
                        res_cnt = 2'd1;
                        nxt     = '{phase: PH_TOP, seg_nonempty: 1'b0, err_hold: 1'b1};
                    end
                end
            endcase
        end
    end

endmodule

@@ design/lfsp_result_buf.sv @@
// Result register: holds the events of one decoded beat and hands them out in order.
`timescale 1ns / 1ps

module lfsp_result_buf
    import lfsp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  lfsp_res_set_t load_res,
    input  logic [1:0]    load_cnt,
    output logic          can_load,
    lfsp_event_if.source  events
);

    lfsp_res_set_t entries_reg;
    logic [1:0]    cnt_reg;
    logic [1:0]    cnt_next;
    logic [1:0]    head_reg;
    logic [1:0]    head_next;
    logic          fire;
    lfsp_res_t     cur_res;

    assign fire = events.valid && events.ready;

    // A new set may replace the last pending event in the cycle it is taken.
    assign can_load = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && events.ready);

    always_comb
    begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        if (load)
        begin
            cnt_next  = load_cnt;
            head_next = 2'd0;
        end
        else if (fire)
        begin
            cnt_next  = cnt_reg - 2'd1;
            head_next = head_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            head_reg <= 2'd0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            head_reg <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entries_reg <= load_res;
        end
    end

    assign cur_res             = entries_reg[head_reg];
    assign events.valid        = (cnt_reg != 2'd0);
    assign events.event_res    = cur_res.event_res;
    assign events.payload_byte = cur_res.payload_byte;
    assign events.has_value    = cur_res.has_value;
    assign events.quoted       = cur_res.quoted;
    assign events.error_cause  = cur_res.error_cause;
    assign events.last         = (cnt_reg == 2'd1);

endmodule

@@ design/link_format_stream_parser.sv @@
// Top level of the byte-serial link-format parser.
//
//  channel  dir  beat contents
//  -------  ---  ---------------------------------------------------------------
//  text     in   kind (end-of-text marker), text_byte
//  events   out  event_res, payload_byte, has_value, quoted, error_cause, last
//
// A text beat is registered, decoded in the next cycle, and its zero to three events
// land in the result register; the parser takes one beat per clock while each beat
// yields at most one event and events is not stalled; a beat's events go out in order.
// Reset clears the parse state, the input register and the result register.
// A stall on events holds the result register; the input register keeps one beat
// waiting, and a new set loads as soon as the last pending event is taken.
`timescale 1ns / 1ps

module link_format_stream_parser
    import lfsp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    lfsp_text_if.sink    text,
    lfsp_event_if.source events
);

    logic          in_valid_reg;
    logic          in_valid_next;
    logic          kind_reg;
    logic [7:0]    byte_reg;
    lfsp_state_t   state_reg;
    lfsp_state_t   state_next;
    lfsp_res_set_t dec_res;
    logic [1:0]    dec_cnt;
    logic          can_load;
    logic          advance;
    logic          accept;

    assign advance    = in_valid_reg && can_load;
    assign text.ready = !in_valid_reg || can_load;
    assign accept     = text.valid && text.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '{phase: PH_TOP, seg_nonempty: 1'b0, err_hold: 1'b0};
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= text.kind;
            byte_reg <= text.text_byte;
        end
    end

    lfsp_decode u_decode (
        .kind      (kind_reg),
        .text_byte (byte_reg),
        .cur       (state_reg),
        .nxt       (state_next),
        .res       (dec_res),
        .res_cnt   (dec_cnt)
    );

    lfsp_result_buf u_result_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .load_res (dec_res),
        .load_cnt (dec_cnt),
        .can_load (can_load),
        .events   (events)
    );

endmodule
